### hdl/jpeg_stream_detector_defines.svh
// assertion macros shared by the jpeg stream detector rtl
`ifndef JPEG_STREAM_DETECTOR_DEFINES_SVH
`define JPEG_STREAM_DETECTOR_DEFINES_SVH
`ifndef SYNTHESIS
`define JSD_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);
`define JSD_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);
`else
`define JSD_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg)
`define JSD_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg)
`endif
`endif

### hdl/jsd_pkg.sv
// types and constants of the jpeg stream detector
`default_nettype none
package jsd_pkg;

  localparam int POS_WIDTH_DEFAULT = 48;
  localparam int FIELD_POS_W = 48;
  localparam int TIMEOUT_W = 24;
  localparam int WINDOW_W = 20;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 24'd262144;
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 20'd4096;

  localparam logic [23:0] SOI_PREFIX = 24'hffd8ff;
  localparam logic [7:0] MARK_FF = 8'hff;
  localparam logic [7:0] MARK_SOF_MASK = 8'hfe;
  localparam logic [7:0] MARK_SOF0 = 8'hc0;
  localparam logic [7:0] MARK_DHT = 8'hc4;
  localparam logic [7:0] MARK_DQT = 8'hdb;
  localparam logic [7:0] MARK_COM = 8'hfe;
  localparam logic [7:0] MARK_SEG_LOW = 8'hc1;
  localparam logic [31:0] SOF_MASK = 32'hfe0000ff;
  localparam logic [31:0] SOF_MATCH = 32'hc0000008;
  localparam logic [15:0] MARK_SOS = 16'hffda;
  localparam logic [15:0] MARK_EOI = 16'hffd9;
  localparam logic [15:0] MARK_SOI = 16'hffd8;
  localparam logic [7:0] RST_MATCH = 8'hd0;
  localparam logic [7:0] RST_MASK = 8'hf8;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_HEAD = 2'd1,
    MODE_SCAN = 2'd2,
    MODE_END  = 2'd3
  } mode_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_HEADER_TIMEOUT       = 2'd0,
    REG_FRAME_TO_SCAN_WINDOW = 2'd1
  } cfg_reg_t;

  typedef enum logic {
    CMD_BYTE  = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [TIMEOUT_W-1:0] header_timeout;
    logic [WINDOW_W-1:0] frame_to_scan_window;
  } cfg_t;

  typedef struct packed {
    logic cmd;
    logic [7:0] data_byte;
    logic new_block;
    logic [FIELD_POS_W-1:0] block_pos;
  } in_item_t;

endpackage
`default_nettype wire

### hdl/jsd_if.sv
// channel interfaces of the jpeg stream detector
`default_nettype none
interface jsd_in_if import jsd_pkg::*; ();
  logic valid;
  logic ready;
  logic cmd;
  logic [7:0] data_byte;
  logic new_block;
  logic [FIELD_POS_W-1:0] block_pos;
  modport source (output valid, cmd, data_byte, new_block, block_pos, input ready);
  modport sink (input valid, cmd, data_byte, new_block, block_pos, output ready);
endinterface

interface jsd_out_if import jsd_pkg::*; ();
  logic valid;
  logic ready;
  logic [1:0] status;
  logic end_now;
  logic [FIELD_POS_W-1:0] image_start;
  logic [FIELD_POS_W-1:0] image_end;
  modport source (output valid, status, end_now, image_start, image_end, input ready);
  modport sink (input valid, status, end_now, image_start, image_end, output ready);
endinterface

interface jsd_cfg_if import jsd_pkg::*; ();
  logic valid;
  logic ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### hdl/jsd_cfg.sv
// configuration registers of the jpeg stream detector
`default_nettype none
module jsd_cfg import jsd_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  jsd_cfg_if.sink cfg_ch,
  output cfg_t cfg
);

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_timeout <= TIMEOUT_RESET;
      cfg.frame_to_scan_window <= WINDOW_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_HEADER_TIMEOUT: cfg.header_timeout <= cfg_ch.data[TIMEOUT_W-1:0];
        REG_FRAME_TO_SCAN_WINDOW: cfg.frame_to_scan_window <= cfg_ch.data[WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

### hdl/jsd_in_reg.sv
// input register stage of the jpeg stream detector
`default_nettype none
`include "jpeg_stream_detector_defines.svh"
module jsd_in_reg import jsd_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  jsd_in_if.sink src,
  output in_item_t item,
  output logic item_valid,
  input wire logic item_take
);

  assign src.ready = !item_valid || item_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (src.ready) begin
      item_valid <= src.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src.valid && src.ready) begin
      item.cmd <= src.cmd;
      item.data_byte <= src.data_byte;
      item.new_block <= src.new_block;
      item.block_pos <= src.block_pos;
    end
  end

  `JSD_ASSERT_NXT(a_accept_held, clk, rst, src.valid && src.ready, item_valid, "accepted transaction not held")

endmodule
`default_nettype wire

### hdl/jsd_core.sv
// marker detection state and result register of the jpeg stream detector
`default_nettype none
`include "jpeg_stream_detector_defines.svh"
module jsd_core import jsd_pkg::*; #(
  parameter int POS_WIDTH = POS_WIDTH_DEFAULT
) (
  input wire logic clk,
  input wire logic rst,
  input wire cfg_t cfg,
  input wire in_item_t item,
  input wire logic item_valid,
  output logic item_take,
  jsd_out_if.source res
);

  mode_t mode, mode_next;
  logic [31:0] window, window_next;
  logic [POS_WIDTH-1:0] position, position_next;
  logic [POS_WIDTH-1:0] soi_pos, soi_pos_next;
  logic [POS_WIDTH-1:0] next_segment_pos, next_segment_pos_next;
  logic [POS_WIDTH-1:0] frame_pos, frame_pos_next;
  logic [POS_WIDTH-1:0] scan_pos, scan_pos_next;
  logic [POS_WIDTH-1:0] eoi_pos, eoi_pos_next;
  logic [POS_WIDTH-1:0] end_pos, end_pos_next;
  logic frame_ok, frame_ok_next;
  logic scan_ok, scan_ok_next;
  logic eoi_ok, eoi_ok_next;
  logic ended;

  logic [7:0] c;
  logic [7:0] older;
  logic [31:0] w;
  logic [POS_WIDTH-1:0] p;
  logic [POS_WIDTH:0] seg_sum;
  logic opens;
  logic seg_hit;
  logic seg_before;
  logic frm_hit;
  logic sos_hit;
  logic timed_out;
  logic end_hit;
  mode_t mode_mid;
  logic [POS_WIDTH-1:0] tmo_ext;
  logic [POS_WIDTH-1:0] win_ext;

  assign item_take = item_valid && (!res.valid || res.ready);

  always_comb begin
    c = item.data_byte;
    older = window[31:24];
    w = {window[23:0], c};
    p = item.new_block ? POS_WIDTH'(item.block_pos) : position;
    tmo_ext = POS_WIDTH'(cfg.header_timeout);
    win_ext = POS_WIDTH'(cfg.frame_to_scan_window);
    opens = (w[31:8] == SOI_PREFIX) &&
            (((c & MARK_SOF_MASK) == MARK_SOF0) || (c == MARK_DHT) ||
             ((c >= MARK_DQT) && (c <= MARK_COM)));
    seg_hit = (next_segment_pos == p) && (w[31:24] == MARK_FF) &&
              (w[23:16] > MARK_SEG_LOW) && (w[23:16] < MARK_FF);
    seg_sum = {1'b0, p} + (POS_WIDTH + 1)'(w[15:0]) + (POS_WIDTH + 1)'(2);
    seg_before = seg_hit ? seg_sum[POS_WIDTH] : (next_segment_pos < p);
    frm_hit = seg_before && (older == MARK_FF) && ((w & SOF_MASK) == SOF_MATCH);
    sos_hit = (w[15:0] == MARK_SOS) &&
              (frm_hit ? ((p > soi_pos) && (win_ext != '0))
                       : (frame_ok && (frame_pos > soi_pos) &&
                          ((p - frame_pos) < win_ext)));

    mode_next = mode;
    window_next = window;
    position_next = position;
    soi_pos_next = soi_pos;
    next_segment_pos_next = next_segment_pos;
    frame_pos_next = frame_pos;
    scan_pos_next = scan_pos;
    eoi_pos_next = eoi_pos;
    end_pos_next = end_pos;
    frame_ok_next = frame_ok;
    scan_ok_next = scan_ok;
    eoi_ok_next = eoi_ok;
    ended = 1'b0;
    mode_mid = mode;
    timed_out = 1'b0;
    end_hit = 1'b0;

    if (item.cmd == CMD_CLEAR) begin
      mode_next = MODE_IDLE;
      window_next = '0;
      position_next = '0;
      soi_pos_next = '0;
      next_segment_pos_next = '0;
      frame_pos_next = '0;
      scan_pos_next = '0;
      eoi_pos_next = '0;
      end_pos_next = '0;
      frame_ok_next = 1'b0;
      scan_ok_next = 1'b0;
      eoi_ok_next = 1'b0;
    end else begin
      window_next = w;
      position_next = p + POS_WIDTH'(1);
      unique case (mode)
        MODE_IDLE: begin
          if (opens) begin
            mode_next = MODE_HEAD;
            soi_pos_next = p;
            next_segment_pos_next = p + POS_WIDTH'(2);
            frame_ok_next = 1'b0;
            scan_ok_next = 1'b0;
            eoi_ok_next = 1'b0;
            frame_pos_next = '0;
            scan_pos_next = '0;
            eoi_pos_next = '0;
          end
        end
        MODE_HEAD, MODE_SCAN: begin
          if (seg_hit) begin
            next_segment_pos_next = seg_sum[POS_WIDTH-1:0];
          end
          if (frm_hit) begin
            frame_pos_next = p;
            frame_ok_next = 1'b1;
          end
          if (sos_hit) begin
            scan_pos_next = p;
            scan_ok_next = 1'b1;
            mode_mid = MODE_SCAN;
          end
          timed_out = ((p - soi_pos) > tmo_ext) && !scan_ok_next;
          mode_next = timed_out ? MODE_IDLE : mode_mid;
          if (!timed_out && (mode_mid == MODE_SCAN)) begin
            if (w[15:0] == MARK_EOI) begin
              eoi_pos_next = p;
              eoi_ok_next = 1'b1;
            end
            end_hit = (scan_ok_next && eoi_ok_next && (w[15:0] == MARK_SOI)) ||
                      (scan_ok_next && (p > scan_pos_next) && (w[15:8] == MARK_FF) &&
                       (c != 8'h00) && ((c & RST_MASK) != RST_MATCH));
            if (end_hit) begin
              mode_next = MODE_END;
              end_pos_next = p + POS_WIDTH'(1);
              ended = 1'b1;
            end
          end
        end
        MODE_END: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      window <= '0;
      position <= '0;
      soi_pos <= '0;
      next_segment_pos <= '0;
      frame_pos <= '0;
      scan_pos <= '0;
      eoi_pos <= '0;
      end_pos <= '0;
      frame_ok <= 1'b0;
      scan_ok <= 1'b0;
      eoi_ok <= 1'b0;
    end else if (item_take) begin
      mode <= mode_next;
      window <= window_next;
      position <= position_next;
      soi_pos <= soi_pos_next;
      next_segment_pos <= next_segment_pos_next;
      frame_pos <= frame_pos_next;
      scan_pos <= scan_pos_next;
      eoi_pos <= eoi_pos_next;
      end_pos <= end_pos_next;
      frame_ok <= frame_ok_next;
      scan_ok <= scan_ok_next;
      eoi_ok <= eoi_ok_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (item_take) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      res.status <= mode_next;
      res.end_now <= ended;
      res.image_start <= (mode_next == MODE_SCAN || mode_next == MODE_END) ?
                         FIELD_POS_W'(soi_pos - POS_WIDTH'(3)) : '0;
      res.image_end <= (mode_next == MODE_END) ? FIELD_POS_W'(end_pos_next) : '0;
    end
  end

  `JSD_ASSERT_IMP(a_end_flag_status, clk, rst, res.valid && res.end_now,
                  res.status == MODE_END, "end flag without ended status")
  `JSD_ASSERT_IMP(a_start_zero, clk, rst,
                  res.valid && (res.status == MODE_IDLE || res.status == MODE_HEAD),
                  res.image_start == '0, "image start set before scan")
  `JSD_ASSERT_NXT(a_end_sticky, clk, rst,
                  mode == MODE_END && !(item_take && item.cmd == CMD_CLEAR),
                  mode == MODE_END, "ended state left without clear")

endmodule
`default_nettype wire

### hdl/jpeg_stream_detector.sv
// top level of the jpeg stream detector
// usage:
//   byte_in carries one transaction per stream byte: cmd 0 scans data_byte
//   (new_block loads block_pos as the byte's position first), cmd 1 clears
//   the detector to idle. result_out returns exactly one transaction per
//   input transaction with status, end_now and the image start/end positions.
//   cfg writes header_timeout (index 0) and frame_to_scan_window (index 1);
//   it is always ready and takes effect on the next byte.
// path: each input transaction is registered in the input register, and
//   its result is registered in the result register.
// throughput: one byte per cycle unless result_out stalls; the detector state
//   updates in a single pass of compare and add logic between the registers.
// reset: rst is synchronous; the detector returns to idle with zero
//   positions and the configuration returns to its default values.
// stall: when result_out is not taken, the result is held, one more byte
//   waits in the input register and byte_in drops ready after that.
`default_nettype none
module jpeg_stream_detector import jsd_pkg::*; #(
  parameter int POS_WIDTH = POS_WIDTH_DEFAULT
) (
  input wire logic clk,
  input wire logic rst,
  jsd_in_if.sink byte_in,
  jsd_out_if.source result_out,
  jsd_cfg_if.sink cfg
);

  cfg_t cfg_regs;
  in_item_t item;
  logic item_valid;
  logic item_take;

  jsd_cfg u_cfg (
    .clk(clk),
    .rst(rst),
    .cfg_ch(cfg),
    .cfg(cfg_regs)
  );

  jsd_in_reg u_in_reg (
    .clk(clk),
    .rst(rst),
    .src(byte_in),
    .item(item),
    .item_valid(item_valid),
    .item_take(item_take)
  );

  jsd_core #(
    .POS_WIDTH(POS_WIDTH)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_regs),
    .item(item),
    .item_valid(item_valid),
    .item_take(item_take),
    .res(result_out)
  );

endmodule
`default_nettype wire

### verif/jsd_checker.sv
// checker of the jpeg stream detector: predicts each result and compares the output channel
module jsd_checker import jsd_pkg::*; (
  input logic clk,
  input logic rst,
  jsd_in_if byte_in,
  jsd_out_if result_out,
  jsd_cfg_if cfg,
  output int unsigned mismatch_count,
  output int unsigned pending_count
);

  localparam int POSW = FIELD_POS_W;
  localparam logic [7:0] STUFF_BYTE = 8'h00;

  typedef struct packed {
    logic [1:0] status;
    logic end_now;
    logic [POSW-1:0] image_start;
    logic [POSW-1:0] image_end;
  } det_result_t;

  logic [TIMEOUT_W-1:0] timeout_lim;
  logic [WINDOW_W-1:0] sos_window;

  mode_t st_mode;
  logic [31:0] win;
  logic [7:0] shifted_out;
  logic [POSW-1:0] pos, soi_at, seg_at, sof_at, sos_at, eoi_at, end_at;
  logic sof_seen, sos_seen, eoi_seen;

  det_result_t expected_results[$];
  det_result_t want, got;
  in_item_t seen;
  int unsigned errors = 0;

  function automatic void clear_detector();
    st_mode = MODE_IDLE;
    win = '0;
    shifted_out = '0;
    pos = '0;
    soi_at = '0;
    seg_at = '0;
    sof_at = '0;
    sos_at = '0;
    eoi_at = '0;
    end_at = '0;
    sof_seen = 1'b0;
    sos_seen = 1'b0;
    eoi_seen = 1'b0;
  endfunction

  function automatic void step_detector(in_item_t it);
    det_result_t r;
    logic [POSW-1:0] p;
    logic [31:0] w;
    logic [7:0] c;
    logic hit_end;
    hit_end = 1'b0;
    if (it.cmd == CMD_CLEAR) begin
      clear_detector();
    end else begin
      if (it.new_block) pos = it.block_pos;
      p = pos;
      c = it.data_byte;
      shifted_out = win[31:24];
      win = {win[23:0], c};
      w = win;
      if (st_mode == MODE_IDLE) begin
        if (w[31:8] == SOI_PREFIX && ((c & MARK_SOF_MASK) == MARK_SOF0 || c == MARK_DHT ||
            (c >= MARK_DQT && c <= MARK_COM))) begin
          st_mode = MODE_HEAD;
          soi_at = p;
          seg_at = p + 2;
          sof_seen = 1'b0;
          sos_seen = 1'b0;
          eoi_seen = 1'b0;
          sof_at = '0;
          sos_at = '0;
          eoi_at = '0;
        end
      end else if (st_mode != MODE_END) begin
        // segment length skip
        if (seg_at == p && w[31:24] == MARK_FF && w[23:16] > MARK_SEG_LOW &&
            w[23:16] < MARK_FF)
          seg_at = p + POSW'(w[15:0]) + 2;
        // SOF0 or SOF1 frame header with 8-bit precision
        if (seg_at < p && shifted_out == MARK_FF && (w & SOF_MASK) == SOF_MATCH) begin
          sof_at = p;
          sof_seen = 1'b1;
        end
        if (sof_seen && sof_at > soi_at && POSW'(p - sof_at) < POSW'(sos_window) &&
            w[15:0] == MARK_SOS) begin
          sos_at = p;
          sos_seen = 1'b1;
          st_mode = MODE_SCAN;
        end
        if (POSW'(p - soi_at) > POSW'(timeout_lim) && !sos_seen) begin
          st_mode = MODE_IDLE;
        end else if (st_mode == MODE_SCAN) begin
          if (w[15:0] == MARK_EOI) begin
            eoi_at = p;
            eoi_seen = 1'b1;
          end
          if ((sos_seen && eoi_seen && w[15:0] == MARK_SOI) ||
              (sos_seen && p > sos_at && w[15:8] == MARK_FF && c != STUFF_BYTE &&
               (c & RST_MASK) != RST_MATCH)) begin
            st_mode = MODE_END;
            end_at = p + 1;
            hit_end = 1'b1;
          end
        end
      end
      pos = pos + 1;
    end
    r.status = st_mode;
    r.end_now = hit_end;
    r.image_start = (st_mode >= MODE_SCAN) ? POSW'(soi_at - 3) : '0;
    r.image_end = (st_mode == MODE_END) ? end_at : '0;
    expected_results.push_back(r);
  endfunction

  function automatic void note_mismatch(string what, det_result_t exp_r, det_result_t act_r);
    errors++;
    if (errors <= 10)
      $display("mismatch (%s): expected status %0d end_now %0d start %h end %h, got status %0d end_now %0d start %h end %h",
               what, exp_r.status, exp_r.end_now, exp_r.image_start, exp_r.image_end,
               act_r.status, act_r.end_now, act_r.image_start, act_r.image_end);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      timeout_lim = TIMEOUT_RESET;
      sos_window = WINDOW_RESET;
      clear_detector();
      expected_results.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_HEADER_TIMEOUT: timeout_lim = cfg.data[TIMEOUT_W-1:0];
          REG_FRAME_TO_SCAN_WINDOW: sos_window = cfg.data[WINDOW_W-1:0];
          default: ;
        endcase
      end
      if (result_out.valid && result_out.ready) begin
        got.status = result_out.status;
        got.end_now = result_out.end_now;
        got.image_start = result_out.image_start;
        got.image_end = result_out.image_end;
        if (expected_results.size() == 0) begin
          note_mismatch("unexpected transaction", '0, got);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status || got.end_now !== want.end_now ||
              got.image_start !== want.image_start || got.image_end !== want.image_end)
            note_mismatch("field", want, got);
        end
      end
      if (byte_in.valid && byte_in.ready) begin
        seen.cmd = byte_in.cmd;
        seen.data_byte = byte_in.data_byte;
        seen.new_block = byte_in.new_block;
        seen.block_pos = byte_in.block_pos;
        step_detector(seen);
      end
    end
    mismatch_count <= errors;
    pending_count <= expected_results.size();
  end

endmodule

### verif/tb_top.sv
// testbench top of the jpeg stream detector: clock, reset, stimulus and verdict
module tb_top;
  import jsd_pkg::*;

  localparam int ITEM_TARGET = 1400;
  localparam int PHASES = 5;
  localparam int CYCLE_LIMIT = 200000;
  localparam int POSW = FIELD_POS_W;
  localparam logic [7:0] MARK_APP0 = 8'he0;
  localparam logic [7:0] MARK_SOF1 = 8'hc1;
  localparam logic [7:0] PREC_BASELINE = 8'h08;
  localparam logic [7:0] STUFF_BYTE = 8'h00;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic quiet = 1'b0;
  int cycle_count = 0;
  int sent_count = 0;
  int unsigned mismatches;
  int unsigned pending;

  in_item_t stream_q[$];

  jsd_in_if byte_in();
  jsd_out_if result_out();
  jsd_cfg_if cfg();

  jpeg_stream_detector u_top (
    .clk(clk),
    .rst(rst),
    .byte_in(byte_in),
    .result_out(result_out),
    .cfg(cfg)
  );

  jsd_checker u_checker (
    .clk(clk),
    .rst(rst),
    .byte_in(byte_in),
    .result_out(result_out),
    .cfg(cfg),
    .mismatch_count(mismatches),
    .pending_count(pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    result_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      result_out.ready <= quiet || ($urandom_range(99) >= 8);
    end
  end

  function automatic logic [POSW-1:0] rand_pos();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic void put_item(cmd_t c, logic [7:0] b, logic nb, logic [POSW-1:0] bp);
    in_item_t it;
    it.cmd = c;
    it.data_byte = b;
    it.new_block = nb;
    it.block_pos = bp;
    stream_q.push_back(it);
  endfunction

  function automatic void put(logic [7:0] b);
    put_item(CMD_BYTE, b, 1'b0, rand_pos());
  endfunction

  function automatic logic [7:0] body_byte();
    return ($urandom_range(7) == 0) ? MARK_FF : 8'($urandom_range(254));
  endfunction

  function automatic int seg_len();
    return ($urandom_range(9) == 0) ? $urandom_range(30, 90) : $urandom_range(2, 10);
  endfunction

  function automatic logic [7:0] table_marker();
    case ($urandom_range(3))
      0: return MARK_DQT;
      1: return MARK_DHT;
      2: return MARK_COM;
      default: return MARK_APP0 | 8'($urandom_range(15));
    endcase
  endfunction

  function automatic void put_segment(logic [7:0] m, int len);
    put(MARK_FF);
    put(m);
    put(8'(len >> 8));
    put(8'(len));
    repeat (len - 2) put(body_byte());
  endfunction

  function automatic void put_sof();
    put(MARK_FF);
    put($urandom_range(1) ? MARK_SOF0 : MARK_SOF1);
    put(8'h00);
    put(8'h0b);
    put(($urandom_range(7) == 0) ? 8'($urandom) : PREC_BASELINE);
    repeat (8) put(8'($urandom_range(254)));
  endfunction

  function automatic void put_jpeg(bit cut_short);
    logic [7:0] m;
    logic [7:0] b;
    logic [POSW-1:0] base;
    int k;
    if ($urandom_range(3) == 0) begin
      base = $urandom_range(1) ? rand_pos() : ({POSW{1'b1}} - POSW'($urandom_range(40)));
      put_item(CMD_BYTE, MARK_FF, 1'b1, base);
    end else begin
      put(MARK_FF);
    end
    put(MARK_SOI[7:0]);
    case ($urandom_range(9))
      0: m = MARK_DQT;
      1: m = MARK_DHT;
      2: m = MARK_COM;
      3: m = MARK_SOF0;
      4: m = 8'($urandom);
      default: m = MARK_APP0 | 8'($urandom_range(15));
    endcase
    if (m == MARK_SOF0) begin
      put(MARK_FF);
      put(m);
      put(8'h00);
      put(8'h0b);
      put(PREC_BASELINE);
      repeat (8) put(8'($urandom_range(254)));
    end else begin
      put_segment(m, seg_len());
      repeat ($urandom_range(2)) put_segment(table_marker(), seg_len());
      put_sof();
    end
    if ($urandom_range(2) == 0) put_segment(MARK_DHT, seg_len());
    if ($urandom_range(7) == 0) repeat ($urandom_range(20, 120)) put(8'($urandom_range(254)));
    if (cut_short) begin
      repeat ($urandom_range(10, 100)) put(body_byte());
    end else begin
      put(MARK_FF);
      put(MARK_SOS[7:0]);
      put(8'h00);
      put(8'h08);
      repeat (6) put(8'($urandom_range(254)));
      repeat ($urandom_range(4, 40)) begin
        b = 8'($urandom);
        put(b);
        if (b == MARK_FF) begin
          k = $urandom_range(9);
          if (k < 5) put(STUFF_BYTE);
          else if (k < 9) put(RST_MATCH | 8'($urandom_range(7)));
          else put(8'($urandom));
        end
      end
      k = $urandom_range(9);
      if (k < 7) begin
        put(MARK_FF);
        put(MARK_EOI[7:0]);
      end else if (k == 7) begin
        put(MARK_FF);
        put(8'($urandom));
      end else if (k == 8) begin
        put(MARK_FF);
        put(MARK_SOI[7:0]);
      end
      if ($urandom_range(3) == 0) begin
        put(MARK_FF);
        put(MARK_SOI[7:0]);
        put(MARK_FF);
        put(MARK_APP0);
      end
    end
  endfunction

  function automatic void put_noise();
    logic [7:0] b;
    repeat ($urandom_range(4, 30)) begin
      b = $urandom_range(1) ? MARK_FF : 8'($urandom);
      if ($urandom_range(19) == 0) put_item(CMD_BYTE, b, 1'b1, rand_pos());
      else put(b);
    end
  endfunction

  function automatic void put_clear();
    put_item(CMD_CLEAR, 8'($urandom), 1'($urandom), rand_pos());
  endfunction

  task automatic push_byte(in_item_t it);
    while (!quiet && $urandom_range(99) < 8) begin
      byte_in.valid <= 1'b0;
      @(posedge clk);
    end
    byte_in.valid <= 1'b1;
    byte_in.cmd <= it.cmd;
    byte_in.data_byte <= it.data_byte;
    byte_in.new_block <= it.new_block;
    byte_in.block_pos <= it.block_pos;
    @(posedge clk);
    while (!byte_in.ready) @(posedge clk);
  endtask

  task automatic flush_stream();
    while (stream_q.size() > 0) begin
      push_byte(stream_q.pop_front());
      sent_count++;
    end
  endtask

  task automatic drain();
    byte_in.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= d;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(int count);
    int start;
    int pick;
    start = sent_count;
    while (sent_count - start < count) begin
      pick = $urandom_range(99);
      if (pick < 65) put_jpeg(1'b0);
      else if (pick < 85) put_noise();
      else if (pick < 93) put_clear();
      else put_jpeg(1'b1);
      flush_stream();
    end
  endtask

  initial begin
    byte_in.valid <= 1'b0;
    byte_in.cmd <= CMD_BYTE;
    byte_in.data_byte <= '0;
    byte_in.new_block <= 1'b0;
    byte_in.block_pos <= '0;
    cfg.valid <= 1'b0;
    cfg.index <= REG_HEADER_TIMEOUT;
    cfg.data <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // wrapped start, app skip, frame, scan with stuffing and restart, eoi, sticky end, clear
    put_item(CMD_BYTE, MARK_FF, 1'b1, {POSW{1'b1}} - 2);
    put(MARK_SOI[7:0]);
    put(MARK_FF);
    put(MARK_APP0);
    put(8'h00);
    put(8'h04);
    put(8'h12);
    put(8'h34);
    put(MARK_FF);
    put(MARK_SOF0);
    put(8'h00);
    put(8'h0b);
    put(PREC_BASELINE);
    put(MARK_FF);
    put(MARK_SOS[7:0]);
    put(STUFF_BYTE);
    put(MARK_FF);
    put(STUFF_BYTE);
    put(MARK_FF);
    put(RST_MATCH | 8'h03);
    put(MARK_FF);
    put(MARK_EOI[7:0]);
    put(MARK_FF);
    put(MARK_SOI[7:0]);
    put_clear();
    flush_stream();
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_HEADER_TIMEOUT, 24'hffffff);
          write_reg(REG_FRAME_TO_SCAN_WINDOW, 24'hffffff);
        end
        1: begin
          write_reg(REG_HEADER_TIMEOUT, 24'd1);
          write_reg(REG_FRAME_TO_SCAN_WINDOW, 24'd1);
        end
        2: begin
          write_reg(REG_HEADER_TIMEOUT, 24'd80);
          write_reg(REG_FRAME_TO_SCAN_WINDOW, 24'd40);
          quiet <= 1'b1;
        end
        3: begin
          write_reg(REG_HEADER_TIMEOUT, 24'($urandom_range(20, 400)));
          write_reg(REG_FRAME_TO_SCAN_WINDOW, 24'($urandom_range(2, 200)));
        end
        default: begin
          write_reg(REG_HEADER_TIMEOUT, 24'(TIMEOUT_RESET));
          write_reg(REG_FRAME_TO_SCAN_WINDOW, 24'(WINDOW_RESET));
        end
      endcase
      run_random(ITEM_TARGET / PHASES);
      drain();
      quiet <= 1'b0;
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/jsd_pkg.sv
hdl/jsd_if.sv
hdl/jsd_cfg.sv
hdl/jsd_in_reg.sv
hdl/jsd_core.sv
hdl/jpeg_stream_detector.sv
verif/jsd_checker.sv
verif/tb_top.sv
